/* hdl/assert_macros.svh */
// Assertion helpers for the checker file of this block.
// LST_ASSERT expects signals named clk_i and rst_ni in the scope where it is used; LST_ASSERT_RST only clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define LST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define LST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/lst_pkg.sv */
`timescale 1ns / 1ps

package lst_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned ENTRY_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FIDX_W   = 6;
  localparam int unsigned RVAL_W   = 32;
  localparam int unsigned ECNT_W   = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND   = 3'd0,
    FN_INSERT   = 3'd1,
    FN_DEL_VAL  = 3'd2,
    FN_DEL_POS  = 3'd3,
    FN_SEARCH   = 3'd4,
    FN_READ     = 3'd5,
    FN_CLEAR    = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [FIDX_W-1:0]        found_index;
    logic signed [RVAL_W-1:0] read_value;
    logic [ECNT_W-1:0]        entry_count;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

endpackage

/* hdl/lst_if.sv */
`timescale 1ns / 1ps

interface lst_req_if import lst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, func, value, position, input ready);
  modport sink (input valid, func, value, position, output ready);
endinterface

interface lst_rsp_if import lst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [FIDX_W-1:0]        found_index;
  logic signed [RVAL_W-1:0] read_value;
  logic [ECNT_W-1:0]        entry_count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, status, found_index, read_value, entry_count, is_empty,
                  is_full, input ready);
  modport sink (input valid, status, found_index, read_value, entry_count, is_empty,
                is_full, output ready);
endinterface

/* hdl/lst_mem.sv */
`timescale 1ns / 1ps

module lst_mem import lst_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  mem_ctl_t                 ctl_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/lst_ctrl.sv */
`timescale 1ns / 1ps

module lst_ctrl import lst_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [FUNC_W-1:0]           req_func_i,
  input  logic signed [VALUE_W-1:0]   req_value_i,
  input  logic [POS_W-1:0]            req_position_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output rsp_t                        rsp_o,
  output mem_ctl_t                    mem_ctl_o,
  output logic [$clog2(CAPACITY)-1:0] mem_rd_addr_o,
  output logic [$clog2(CAPACITY)-1:0] mem_wr_addr_o,
  output logic [ENTRY_WIDTH-1:0]      mem_wr_data_o,
  input  logic [ENTRY_WIDTH-1:0]      mem_rd_data_i
);

  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned EW   = ENTRY_WIDTH;

  state_e               state_q, state_d;
  logic [FUNC_W-1:0]    op_q, op_d;
  logic [EW-1:0]        val_q, val_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [CW-1:0]        count_q, count_d;
  logic [IW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        left_q, left_d;
  logic [CW-1:0]        wcnt_q, wcnt_d;
  logic                 pend_q, pend_d;
  logic [IW-1:0]        pidx_q, pidx_d;
  logic                 hit_q, hit_d;
  logic [IW-1:0]        fidx_q, fidx_d;
  logic [EW-1:0]        rval_q, rval_d;
  status_e              stat_q, stat_d;
  logic                 rsp_valid_q, rsp_valid_d;
  rsp_t                 rsp_q, rsp_d;

  logic                 is_full;
  logic                 is_empty;
  logic                 pos_bad;
  logic                 issue;
  logic                 match;
  logic [IW-1:0]        pos_a;
  logic [CMPW-1:0]      count_c;
  logic [CMPW-1:0]      pos_c;

  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign count_c  = CMPW'(count_q);
  assign pos_c    = CMPW'(pos_q);
  assign pos_bad  = (pos_c >= count_c);
  assign pos_a    = IW'(pos_q);
  // The one comparator that the delete-by-value and search scans share.
  assign match    = (mem_rd_data_i == val_q);
  // A search stops issuing reads once it has found its entry.
  assign issue    = (left_q != '0) && !hit_q;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    val_d         = val_q;
    pos_d         = pos_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    left_d        = left_q;
    wcnt_d        = wcnt_q;
    pend_d        = pend_q;
    pidx_d        = pidx_q;
    hit_d         = hit_q;
    fidx_d        = fidx_q;
    rval_d        = rval_q;
    stat_d        = stat_q;
    rsp_valid_d   = rsp_valid_q && !rsp_ready_i;
    rsp_d         = rsp_q;
    req_ready_o   = 1'b0;
    mem_ctl_o     = '0;
    mem_rd_addr_o = ptr_q;
    mem_wr_addr_o = '0;
    mem_wr_data_o = val_q;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d    = req_func_i;
          val_d   = EW'(req_value_i);
          pos_d   = req_position_i;
          state_d = S_START;
        end
      end

      S_START: begin
        stat_d  = STAT_OK;
        hit_d   = 1'b0;
        fidx_d  = '0;
        rval_d  = '0;
        wcnt_d  = '0;
        pend_d  = 1'b0;
        left_d  = '0;
        state_d = S_FINISH;
        unique case (op_q)
          FN_APPEND: begin
            if (is_full) begin
              stat_d = STAT_FULL;
            end else begin
              mem_ctl_o.wr_en = 1'b1;
              mem_wr_addr_o   = count_q[IW-1:0];
              count_d         = CW'(count_q + 1'b1);
            end
          end
          FN_INSERT: begin
            if (is_full) begin
              stat_d = STAT_FULL;
            end else begin
              // Move entries up from the tail down to index zero.
              ptr_d   = IW'(count_q - 1'b1);
              left_d  = count_q;
              state_d = S_SCAN;
            end
          end
          FN_DEL_VAL, FN_SEARCH: begin
            if (is_empty) begin
              stat_d = STAT_EMPTY;
            end else begin
              ptr_d   = '0;
              left_d  = count_q;
              state_d = S_SCAN;
            end
          end
          FN_DEL_POS: begin
            if (is_empty) begin
              stat_d = STAT_EMPTY;
            end else if (pos_bad) begin
              stat_d = STAT_BADPOS;
            end else begin
              ptr_d   = IW'(pos_a + 1'b1);
              left_d  = CW'(count_c - pos_c - 1'b1);
              state_d = S_SCAN;
            end
          end
          FN_READ: begin
            if (is_empty) begin
              stat_d = STAT_EMPTY;
            end else if (pos_bad) begin
              stat_d = STAT_BADPOS;
            end else begin
              ptr_d   = pos_a;
              left_d  = CW'(1);
              state_d = S_SCAN;
            end
          end
          FN_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        if (issue) begin
          mem_ctl_o.rd_en = 1'b1;
          ptr_d  = (op_q == FN_INSERT) ? IW'(ptr_q - 1'b1) : IW'(ptr_q + 1'b1);
          left_d = CW'(left_q - 1'b1);
        end
        pend_d = issue;
        pidx_d = ptr_q;

        if (pend_q) begin
          // Handle the entry read in the previous cycle.
          unique case (op_q)
            FN_INSERT: begin
              mem_ctl_o.wr_en = 1'b1;
              mem_wr_addr_o   = IW'(pidx_q + 1'b1);
              mem_wr_data_o   = mem_rd_data_i;
            end
            FN_DEL_VAL: begin
              if (!match) begin
                mem_ctl_o.wr_en = 1'b1;
                mem_wr_addr_o   = wcnt_q[IW-1:0];
                mem_wr_data_o   = mem_rd_data_i;
                wcnt_d          = CW'(wcnt_q + 1'b1);
              end
            end
            FN_DEL_POS: begin
              mem_ctl_o.wr_en = 1'b1;
              mem_wr_addr_o   = IW'(pidx_q - 1'b1);
              mem_wr_data_o   = mem_rd_data_i;
            end
            FN_SEARCH: begin
              if (match && !hit_q) begin
                hit_d  = 1'b1;
                fidx_d = pidx_q;
              end
            end
            FN_READ: begin
              rval_d = mem_rd_data_i;
            end
            default: begin
            end
          endcase
        end else if (!issue) begin
          state_d = S_FINISH;
          unique case (op_q)
            FN_INSERT: begin
              mem_ctl_o.wr_en = 1'b1;
              mem_wr_addr_o   = '0;
              mem_wr_data_o   = val_q;
              count_d         = CW'(count_q + 1'b1);
            end
            FN_DEL_VAL: begin
              stat_d  = (wcnt_q == count_q) ? STAT_NOTFOUND : STAT_OK;
              count_d = wcnt_q;
            end
            FN_DEL_POS: begin
              count_d = CW'(count_q - 1'b1);
            end
            FN_SEARCH: begin
              stat_d = hit_q ? STAT_OK : STAT_NOTFOUND;
            end
            default: begin
            end
          endcase
        end
      end

      S_FINISH: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = stat_q;
          rsp_d.found_index = FIDX_W'(fidx_q);
          rsp_d.read_value  = RVAL_W'(rval_q);
          rsp_d.entry_count = ECNT_W'(count_q);
          rsp_d.is_empty    = is_empty;
          rsp_d.is_full     = is_full;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    ptr_q  <= ptr_d;
    wcnt_q <= wcnt_d;
    pidx_q <= pidx_d;
    fidx_q <= fidx_d;
    rval_q <= rval_d;
    stat_q <= stat_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* hdl/sequential_list_table_unit.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// req_i    | in        | func, value, position
// rsp_o    | out       | status, found_index, read_value, entry_count, is_empty, is_full
//
// Append, clear and rejected requests pass through the start and finish states to the result;
// read, head insert and both deletes also pass through the scan state, which walks the list:
// the entry memory has one read and one write port, so the scan moves one entry per cycle.
// Search scans the list too and stops issuing reads after the first match.
// Reset clears the count and the control state; entry contents are not cleared.
// The input closes while an item is in progress; a held result stalls the next item at its end.

module sequential_list_table_unit import lst_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lst_req_if.sink    req_i,
  lst_rsp_if.source  rsp_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  mem_ctl_t               mem_ctl;
  logic [IW-1:0]          mem_rd_addr;
  logic [IW-1:0]          mem_wr_addr;
  logic [ENTRY_WIDTH-1:0] mem_wr_data;
  logic [ENTRY_WIDTH-1:0] mem_rd_data;
  rsp_t                   rsp;

  lst_ctrl #(
    .CAPACITY   (CAPACITY),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_func_i    (req_i.func),
    .req_value_i   (req_i.value),
    .req_position_i(req_i.position),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_o         (rsp),
    .mem_ctl_o     (mem_ctl),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_data_i (mem_rd_data)
  );

  lst_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(ENTRY_WIDTH)
  ) u_mem (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .rd_addr_i(mem_rd_addr),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data),
    .rd_data_o(mem_rd_data)
  );

  assign rsp_o.status      = rsp.status;
  assign rsp_o.found_index = rsp.found_index;
  assign rsp_o.read_value  = rsp.read_value;
  assign rsp_o.entry_count = rsp.entry_count;
  assign rsp_o.is_empty    = rsp.is_empty;
  assign rsp_o.is_full     = rsp.is_full;

endmodule

/* hdl/lst_chk.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lst_chk import lst_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [ECNT_W-1:0]   rsp_entry_count_i,
  input logic                rsp_is_empty_i,
  input logic                rsp_is_full_i
);

  logic                       req_acc;
  logic                       rsp_stall;
  logic [STATUS_W+ECNT_W-1:0] rsp_key;
  logic                       rsp_full_st;
  logic                       rsp_cap_ok;
  logic                       rsp_empty_ok;

  assign req_acc      = req_valid_i && req_ready_i;
  assign rsp_stall    = rsp_valid_i && !rsp_ready_i;
  assign rsp_key      = {rsp_status_i, rsp_entry_count_i};
  assign rsp_full_st  = rsp_valid_i && (rsp_status_i == STAT_FULL);
  assign rsp_cap_ok   = rsp_is_full_i && !rsp_is_empty_i &&
                        (rsp_entry_count_i == ECNT_W'(CAPACITY));
  assign rsp_empty_ok = (rsp_entry_count_i == '0) && !rsp_is_full_i;

  // Reset leaves no result pending.
  `LST_ASSERT_RST(a_rst_no_rsp, !rst_ni |-> !rsp_valid_i, "result valid during reset")

  // One item at a time: the input closes right after an item is taken.
  `LST_ASSERT(a_busy_after_accept, req_acc |=> !req_ready_i, "ready after accept")

  // A stalled result keeps its status and count.
  `LST_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid_i && $stable(rsp_key), "stalled result changed")

  // A rejected insertion reports a full list.
  `LST_ASSERT(a_full_status, rsp_full_st |-> rsp_cap_ok, "full status without full list")

  // An empty list reports a zero count and cannot be full.
  `LST_ASSERT(a_empty_flag, rsp_valid_i && rsp_is_empty_i |-> rsp_empty_ok, "bad empty flag")

endmodule

bind sequential_list_table_unit lst_chk #(
  .CAPACITY(CAPACITY)
) u_lst_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_entry_count_i(rsp_o.entry_count),
  .rsp_is_empty_i   (rsp_o.is_empty),
  .rsp_is_full_i    (rsp_o.is_full)
);

/* test/tb_sequential_list_table_unit.sv */
`timescale 1ns / 1ps

module tb_sequential_list_table_unit;
  import lst_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned QUIET_MAX  = 5000;
  localparam int unsigned TAIL_WAIT  = 80;
  localparam int unsigned PHASE_ITEMS = 400;

  // Shadow copy of the list that predicts one response per accepted request
  // and holds the responses still owed by the block.
  class list_table_shadow;
    logic signed [VALUE_W-1:0] list_mem[CAP];
    int unsigned               fill;
    rsp_t                      due[$];
    int unsigned               mismatches;
    int unsigned               checked;
    int unsigned               at_capacity;

    function new();
      fill = 0;
      mismatches = 0;
      checked = 0;
      at_capacity = 0;
    endfunction

    function void apply_request(logic [FUNC_W-1:0] fn, logic signed [VALUE_W-1:0] val,
                                logic [POS_W-1:0] pos);
      rsp_t        r;
      int unsigned w;
      r = '0;
      r.status = STAT_OK;
      case (fn)
        FN_APPEND: begin
          if (fill >= CAP) begin
            r.status = STAT_FULL;
          end else begin
            list_mem[fill] = val;
            fill++;
          end
        end
        FN_INSERT: begin
          if (fill >= CAP) begin
            r.status = STAT_FULL;
          end else begin
            for (int i = fill; i > 0; i--) list_mem[i] = list_mem[i-1];
            list_mem[0] = val;
            fill++;
          end
        end
        FN_DEL_VAL: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            w = 0;
            for (int i = 0; i < fill; i++) begin
              if (list_mem[i] != val) begin
                list_mem[w] = list_mem[i];
                w++;
              end
            end
            if (w == fill) r.status = STAT_NOTFOUND;
            fill = w;
          end
        end
        FN_DEL_POS: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else if (pos >= fill) begin
            r.status = STAT_BADPOS;
          end else begin
            for (int j = pos; j + 1 < fill; j++) list_mem[j] = list_mem[j+1];
            fill--;
          end
        end
        FN_SEARCH: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.status = STAT_NOTFOUND;
            for (int i = 0; i < fill; i++) begin
              if (list_mem[i] == val) begin
                r.status = STAT_OK;
                r.found_index = i[FIDX_W-1:0];
                break;
              end
            end
          end
        end
        FN_READ: begin
          if (fill == 0) r.status = STAT_EMPTY;
          else if (pos >= fill) r.status = STAT_BADPOS;
          else r.read_value = list_mem[pos];
        end
        FN_CLEAR: fill = 0;
        default: ;
      endcase
      r.entry_count = fill[ECNT_W-1:0];
      r.is_empty = (fill == 0);
      r.is_full = (fill == CAP);
      if (r.is_full) at_capacity++;
      due.push_back(r);
    endfunction

    function bit field_ok(string label, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, label, exp_v, act_v);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void match_response(rsp_t got);
      rsp_t exp_r;
      bit   good;
      if (due.size() == 0) begin
        $display("%0t: response with nothing outstanding, actual %h", $time, got);
        mismatches++;
        return;
      end
      exp_r = due.pop_front();
      checked++;
      good = field_ok("status", 32'(exp_r.status), 32'(got.status));
      good &= field_ok("found_index", 32'(exp_r.found_index), 32'(got.found_index));
      good &= field_ok("read_value", exp_r.read_value, got.read_value);
      good &= field_ok("entry_count", 32'(exp_r.entry_count), 32'(got.entry_count));
      good &= field_ok("is_empty", 32'(exp_r.is_empty), 32'(got.is_empty));
      good &= field_ok("is_full", 32'(exp_r.is_full), 32'(got.is_full));
      if (!good) mismatches++;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lst_req_if req_if ();
  lst_rsp_if rsp_if ();

  sequential_list_table_unit u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  list_table_shadow          shadow;
  int unsigned               req_idle_pct;
  int unsigned               rsp_idle_pct;
  int unsigned               hold_requests;
  int unsigned               items_sent;
  int unsigned               quiet_cycles = 0;
  logic signed [VALUE_W-1:0] value_pool[8];

  // Response side: random stalls, plus a long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left = 0;
    holds_seen = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = ($urandom_range(0, 99) >= rsp_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.status      = rsp_if.status;
      got.found_index = rsp_if.found_index;
      got.read_value  = rsp_if.read_value;
      got.entry_count = rsp_if.entry_count;
      got.is_empty    = rsp_if.is_empty;
      got.is_full     = rsp_if.is_full;
      shadow.match_response(got);
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_MAX) begin
        $display("Timeout after %0d cycles without progress", QUIET_MAX);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic signed [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
    @(negedge clk);
    req_if.valid    = 1'b1;
    req_if.func     = fn;
    req_if.value    = val;
    req_if.position = pos;
    do @(posedge clk); while (!req_if.ready);
    shadow.apply_request(fn, val, pos);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (shadow.fill > 0 && $urandom_range(0, 9) < 7) begin
      return POS_W'($urandom_range(0, shadow.fill - 1));
    end
    return POS_W'($urandom_range(0, 63));
  endfunction

  // Fills the list to capacity, pushes against the full list, then works at the top slot.
  task automatic grow_to_capacity();
    while (shadow.fill < CAP) begin
      send_item($urandom_range(0, 1) ? FN_APPEND : FN_INSERT, pick_value(), pick_position());
    end
    send_item(FN_APPEND, pick_value(), pick_position());
    send_item(FN_INSERT, pick_value(), pick_position());
    send_item(FN_READ, pick_value(), 6'd63);
    send_item(FN_SEARCH, pick_value(), pick_position());
    send_item(FN_DEL_POS, pick_value(), 6'd63);
  endtask

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) send_item(FN_CLEAR, pick_value(), pick_position());
    else if (r < 30) send_item(FN_APPEND, pick_value(), pick_position());
    else if (r < 45) send_item(FN_INSERT, pick_value(), pick_position());
    else if (r < 60) send_item(FN_DEL_VAL, pick_value(), pick_position());
    else if (r < 72) send_item(FN_DEL_POS, pick_value(), pick_position());
    else if (r < 86) send_item(FN_SEARCH, pick_value(), pick_position());
    else send_item(FN_READ, pick_value(), pick_position());
  endtask

  task automatic run_phase(input int unsigned req_pct, input int unsigned rsp_pct,
                           input bit with_hold);
    int unsigned goal;
    bit          paused;
    req_idle_pct = req_pct;
    rsp_idle_pct = rsp_pct;
    goal = items_sent + PHASE_ITEMS;
    paused = 1'b0;
    if (with_hold) hold_requests++;
    while (items_sent < goal) begin
      if (!paused && items_sent + PHASE_ITEMS / 2 >= goal) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 199) < 3) grow_to_capacity();
      else random_request();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.func = FN_APPEND;
    req_if.value = '0;
    req_if.position = '0;
    req_idle_pct = 29;
    rsp_idle_pct = 83;
    hold_requests = 0;
    items_sent = 0;
    shadow = new();
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every operation but insert against the empty list first.
    send_item(FN_SEARCH, 32'sd5, 6'd0);
    send_item(FN_READ, 32'sd0, 6'd0);
    send_item(FN_DEL_VAL, 32'sd0, 6'd0);
    send_item(FN_DEL_POS, 32'sd0, 6'd63);
    send_item(FN_CLEAR, 32'sd0, 6'd0);
    send_item(FN_APPEND, 32'sh8000_0000, 6'd0);
    send_item(FN_APPEND, 32'sh7fff_ffff, 6'd0);
    send_item(FN_INSERT, 32'sd0, 6'd0);
    send_item(FN_INSERT, -32'sd1, 6'd63);
    send_item(FN_APPEND, 32'sd5, 6'd0);
    send_item(FN_APPEND, 32'sd5, 6'd0);
    send_item(FN_APPEND, 32'sd5, 6'd0);
    send_item(FN_APPEND, 32'sh7fff_ffff, 6'd0);
    send_item(FN_SEARCH, 32'sh7fff_ffff, 6'd0);
    send_item(FN_SEARCH, 32'sd12345, 6'd0);
    send_item(FN_READ, 32'sd0, 6'd63);
    send_item(FN_READ, 32'sd0, 6'd1);
    send_item(FN_DEL_POS, 32'sd0, 6'd63);
    // A run of three adjacent equal entries must all go.
    send_item(FN_DEL_VAL, 32'sd5, 6'd0);
    send_item(FN_DEL_VAL, 32'sh7fff_ffff, 6'd0);
    send_item(FN_DEL_VAL, 32'sd5, 6'd0);
    send_item(FN_DEL_POS, 32'sd0, 6'd0);
    send_item(FN_CLEAR, 32'sd0, 6'd0);

    grow_to_capacity();
    run_phase(29, 83, 1'b0);
    run_phase(83, 29, 1'b0);
    run_phase(0, 0, 1'b1);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Sent %0d requests over all seven operations; checked %0d responses.",
             items_sent, shadow.checked);
    $display("The list stood at capacity after %0d requests; one long response hold-off.",
             shadow.at_capacity);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
